[rtl/integer_matrix_multiply_defines.svh]
// Assertion macros shared by the matrix multiply RTL.
// Depends on nothing; the using module must have clk and arst_n in scope.
`ifndef INTEGER_MATRIX_MULTIPLY_DEFINES_SVH
`define INTEGER_MATRIX_MULTIPLY_DEFINES_SVH
`ifndef SYNTHESIS
`define IMM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define IMM_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IMM_ASSERT(label, prop, msg)
`define IMM_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

[rtl/imm_pkg.sv]
// Shared constants, codes and types for the integer matrix multiply block.
// No dependencies.
package imm_pkg;
	localparam int MAX_DIM     = 64;
	localparam int IDX_W       = 6;
	localparam int SIZE_W      = 7;
	localparam int DATA_W      = 16;
	localparam int MUL_W       = 2 * DATA_W;
	localparam int PROD_W      = 38;
	localparam int ADDR_W      = 2 * IDX_W;
	localparam int RAM_DEPTH   = MAX_DIM * MAX_DIM;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	typedef enum logic [1:0] {
		KIND_WRITE_A = 2'd0,
		KIND_WRITE_B = 2'd1,
		KIND_QUERY   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		OP_WRITE_A    = 2'd0,
		OP_WRITE_B    = 2'd1,
		OP_QUERY      = 2'd2,
		OP_QUERY_ZERO = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_RUN   = 2'd1,
		ST_DRAIN = 2'd2
	} back_state_t;

	typedef struct packed {
		op_t                      op;
		logic [IDX_W-1:0]         row;
		logic [IDX_W-1:0]         col;
		logic signed [DATA_W-1:0] value;
		logic [IDX_W-1:0]         last;
	} entry_t;

	typedef struct packed {
		logic   valid;
		entry_t entry;
	} qhead_t;
endpackage

[rtl/integer_matrix_multiply.sv]
// Top level of the integer matrix multiply block: size register, front end,
// queue and back end. Depends on imm_pkg, imm_front, imm_queue and imm_back.
//
// Usage: a request (kind, row, col, element_value) is taken at a rising edge
// where start is high and busy is low. Kind 0 writes an element of A, kind 1
// an element of B, kind 2 asks for element (row, col) of C = A * B; kind 3 is
// dropped. Each query gives exactly one result on product_row, product_col and
// product_value, marked by done for one cycle; writes give none. The receiver
// has no way to stall, so every result is taken in its strobe cycle.
// The user must write the size N through cfg_we and cfg_wdata only while idle; the
// block does not enforce this. Zero acts as one and values above 64 act as 64.
// Requests pass through a two-entry queue; busy is high while it is full.
// Writes reach their RAM from the queue one per cycle while the back end idles.
// A query reads one element pair per cycle from the two element RAMs, so it
// occupies the back end until its last product is accumulated. Queries outside
// the N by N matrix return zero without reading the RAMs. Reset sets N to 64
// and empties the queue; the element RAMs are not cleared and must be written
// before they are used.
module integer_matrix_multiply (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [1:0]                         kind,
	input  logic [imm_pkg::IDX_W-1:0]          row,
	input  logic [imm_pkg::IDX_W-1:0]          col,
	input  logic signed [imm_pkg::DATA_W-1:0]  element_value,
	input  logic                               cfg_we,
	input  logic [imm_pkg::SIZE_W-1:0]         cfg_wdata,
	output logic                               done,
	output logic [imm_pkg::IDX_W-1:0]          product_row,
	output logic [imm_pkg::IDX_W-1:0]          product_col,
	output logic signed [imm_pkg::PROD_W-1:0]  product_value
);
	logic [imm_pkg::SIZE_W-1:0] matrix_size_q;
	logic                       full, push, pop;
	imm_pkg::entry_t            entry;
	imm_pkg::qhead_t            head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matrix_size_q <= imm_pkg::SIZE_W'(imm_pkg::MAX_DIM);
		end else if (cfg_we) begin
			matrix_size_q <= cfg_wdata;
		end
	end

	imm_front u_front (
		.start         (start),
		.full          (full),
		.kind          (kind),
		.row           (row),
		.col           (col),
		.element_value (element_value),
		.matrix_size   (matrix_size_q),
		.busy          (busy),
		.push          (push),
		.entry         (entry)
	);

	imm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (entry),
		.pop        (pop),
		.full       (full),
		.head       (head)
	);

	imm_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.pop           (pop),
		.done          (done),
		.product_row   (product_row),
		.product_col   (product_col),
		.product_value (product_value)
	);
endmodule

[rtl/imm_ram.sv]
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module imm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

[rtl/imm_front.sv]
// Front end: accepts requests, clamps the matrix size and classifies each request.
// Depends on imm_pkg.
module imm_front (
	input  logic                        start,
	input  logic                        full,
	input  logic [1:0]                  kind,
	input  logic [imm_pkg::IDX_W-1:0]   row,
	input  logic [imm_pkg::IDX_W-1:0]   col,
	input  logic signed [imm_pkg::DATA_W-1:0] element_value,
	input  logic [imm_pkg::SIZE_W-1:0]  matrix_size,
	output logic                        busy,
	output logic                        push,
	output imm_pkg::entry_t             entry
);
	logic [imm_pkg::SIZE_W-1:0] n_eff;
	logic                       in_range;
	logic                       known;

	always_comb begin
		n_eff = matrix_size;
		if (matrix_size == '0) begin
			n_eff = imm_pkg::SIZE_W'(1);
		end else if (matrix_size > imm_pkg::SIZE_W'(imm_pkg::MAX_DIM)) begin
			n_eff = imm_pkg::SIZE_W'(imm_pkg::MAX_DIM);
		end
		in_range = ({1'b0, row} < n_eff) && ({1'b0, col} < n_eff);

		entry.row   = row;
		entry.col   = col;
		entry.value = element_value;
		entry.last  = imm_pkg::IDX_W'(n_eff - imm_pkg::SIZE_W'(1));
		entry.op    = imm_pkg::OP_WRITE_A;
		known       = 1'b1;
		case (imm_pkg::kind_t'(kind))
			imm_pkg::KIND_WRITE_A: begin
				entry.op = imm_pkg::OP_WRITE_A;
			end
			imm_pkg::KIND_WRITE_B: begin
				entry.op = imm_pkg::OP_WRITE_B;
			end
			imm_pkg::KIND_QUERY: begin
				entry.op = in_range ? imm_pkg::OP_QUERY : imm_pkg::OP_QUERY_ZERO;
			end
			default: begin
				known = 1'b0;
			end
		endcase
	end

	assign busy = full;
	assign push = start && !full && known;
endmodule

[rtl/imm_queue.sv]
// Short request queue between the front end and the back end.
// Depends on imm_pkg.
module imm_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  imm_pkg::entry_t push_entry,
	input  logic            pop,
	output logic            full,
	output imm_pkg::qhead_t head
);
	imm_pkg::entry_t             mem_q [imm_pkg::QUEUE_DEPTH];
	logic [imm_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [imm_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [imm_pkg::QCNT_W-1:0]  count_q;
	logic                        do_pop;

	function automatic logic [imm_pkg::QPTR_W-1:0] next_ptr(
		input logic [imm_pkg::QPTR_W-1:0] p
	);
		if (p == imm_pkg::QPTR_W'(imm_pkg::QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return p + imm_pkg::QPTR_W'(1);
	endfunction

	assign full       = (count_q == imm_pkg::QCNT_W'(imm_pkg::QUEUE_DEPTH));
	assign head.valid = (count_q != '0);
	assign head.entry = mem_q[rd_ptr_q];
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !do_pop) begin
				count_q <= count_q + imm_pkg::QCNT_W'(1);
			end else if (do_pop && !push) begin
				count_q <= count_q - imm_pkg::QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end
endmodule

[rtl/imm_back.sv]
// Back end: executes element writes and accumulates dot products for queries.
// Depends on imm_pkg, imm_ram and the assertion macros header.
`include "integer_matrix_multiply_defines.svh"
module imm_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  imm_pkg::qhead_t                    head,
	output logic                               pop,
	output logic                               done,
	output logic [imm_pkg::IDX_W-1:0]          product_row,
	output logic [imm_pkg::IDX_W-1:0]          product_col,
	output logic signed [imm_pkg::PROD_W-1:0]  product_value
);
	imm_pkg::back_state_t state_q, state_d;
	logic                       a_we, b_we, start_query, zero_result, issue;
	logic [imm_pkg::IDX_W-1:0]  k_q, row_q, col_q, last_q;
	logic [imm_pkg::DATA_W-1:0] a_rdata, b_rdata;
	logic                       valid_s1, last_s1, valid_s2, last_s2;
	logic signed [imm_pkg::MUL_W-1:0]  prod_s2;
	logic signed [imm_pkg::PROD_W-1:0] acc_q, prod_ext, acc_sum;
	logic                       finish;

	imm_ram #(.WIDTH(imm_pkg::DATA_W), .DEPTH(imm_pkg::RAM_DEPTH)) u_a_ram (
		.clk   (clk),
		.we    (a_we),
		.waddr ({head.entry.row, head.entry.col}),
		.wdata (head.entry.value),
		.raddr ({row_q, k_q}),
		.rdata (a_rdata)
	);

	imm_ram #(.WIDTH(imm_pkg::DATA_W), .DEPTH(imm_pkg::RAM_DEPTH)) u_b_ram (
		.clk   (clk),
		.we    (b_we),
		.waddr ({head.entry.row, head.entry.col}),
		.wdata (head.entry.value),
		.raddr ({k_q, col_q}),
		.rdata (b_rdata)
	);

	assign prod_ext = {{(imm_pkg::PROD_W - imm_pkg::MUL_W){prod_s2[imm_pkg::MUL_W-1]}}, prod_s2};
	assign acc_sum  = acc_q + prod_ext;
	assign finish   = valid_s2 && last_s2;

	always_comb begin
		state_d     = state_q;
		pop         = 1'b0;
		a_we        = 1'b0;
		b_we        = 1'b0;
		start_query = 1'b0;
		zero_result = 1'b0;
		issue       = 1'b0;
		case (state_q)
			imm_pkg::ST_IDLE: begin
				if (head.valid) begin
					pop = 1'b1;
					case (head.entry.op)
						imm_pkg::OP_WRITE_A: begin
							a_we = 1'b1;
						end
						imm_pkg::OP_WRITE_B: begin
							b_we = 1'b1;
						end
						imm_pkg::OP_QUERY: begin
							start_query = 1'b1;
							state_d     = imm_pkg::ST_RUN;
						end
						imm_pkg::OP_QUERY_ZERO: begin
							zero_result = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			imm_pkg::ST_RUN: begin
				issue = 1'b1;
				if (k_q == last_q) begin
					state_d = imm_pkg::ST_DRAIN;
				end
			end
			imm_pkg::ST_DRAIN: begin
				if (finish) begin
					state_d = imm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = imm_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= imm_pkg::ST_IDLE;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			done     <= 1'b0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= issue;
			valid_s2 <= valid_s1;
			done     <= zero_result || finish;
		end
	end

	always_ff @(posedge clk) begin
		if (start_query) begin
			k_q    <= '0;
			row_q  <= head.entry.row;
			col_q  <= head.entry.col;
			last_q <= head.entry.last;
			acc_q  <= '0;
		end else begin
			if (issue) begin
				k_q <= k_q + imm_pkg::IDX_W'(1);
			end
			if (valid_s2) begin
				acc_q <= acc_sum;
			end
		end
		last_s1 <= (k_q == last_q);
		last_s2 <= last_s1;
		prod_s2 <= $signed(a_rdata) * $signed(b_rdata);
		if (zero_result) begin
			product_row   <= head.entry.row;
			product_col   <= head.entry.col;
			product_value <= '0;
		end else if (finish) begin
			product_row   <= row_q;
			product_col   <= col_q;
			product_value <= acc_sum;
		end
	end

	`IMM_ASSERT(a_finish_strobes, finish |=> done, "last product did not raise the result strobe")
	`IMM_ASSERT(a_run_feeds_pipe, (state_q == imm_pkg::ST_RUN) |=> valid_s1,
		"read issued without pipeline valid")
	`IMM_ASSERT(a_done_in_idle, done |-> (state_q == imm_pkg::ST_IDLE),
		"result strobe outside idle state")
endmodule
